// ===== sv/y2r_pkg.sv =====
// shared types, constants and coefficient derivation for the yuv444 to rgb888 converter
// no dependencies; used by y2r_cfg, y2r_pipe and yuv444_to_rgb888_converter
`default_nettype none

package y2r_pkg;

  // field and datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int COLOR_W   = 8;
  localparam int STD_W     = 2;
  localparam int DEPTH_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam int SMP_W     = SAMPLE_W + 2;    // offset-removed sample, signed
  localparam int COEF_W    = 27;              // widest coefficient, signed
  localparam int PROD_W    = SMP_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHAMT_W   = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'd1;

  // color standard codes
  localparam logic [STD_W-1:0] STD_601  = 2'd0;
  localparam logic [STD_W-1:0] STD_709  = 2'd1;
  localparam logic [STD_W-1:0] STD_2020 = 2'd2;
  localparam logic [STD_W-1:0] STD_RSV  = 2'd3;

  localparam logic [STD_W-1:0]   STD_RESET   = STD_709;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd16;

  // order: luma, red from cr, green from cb, green from cr, blue from cb
  localparam logic signed [COEF_W-1:0] COEF8 [0:2][0:4] = '{
    '{27'sd76309, 27'sd104597, -27'sd25675, -27'sd53279, 27'sd132201},
    '{27'sd76309, 27'sd117489, -27'sd13975, -27'sd34925, 27'sd138438},
    '{27'sd76309, 27'sd110013, -27'sd12276, -27'sd42626, 27'sd140363}
  };

  localparam logic signed [COEF_W-1:0] COEFHI [0:1][0:4] = '{
    '{27'sd19535114, 27'sd26776886, -27'sd6572681, -27'sd13639334, 27'sd33843539},
    '{27'sd19535114, 27'sd30077204, -27'sd3577718, -27'sd8940735, 27'sd35440221}
  };

  typedef struct packed {
    logic signed [COEF_W-1:0] luma;
    logic signed [COEF_W-1:0] r_cr;
    logic signed [COEF_W-1:0] g_cb;
    logic signed [COEF_W-1:0] g_cr;
    logic signed [COEF_W-1:0] b_cb;
  } coef_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mask;
    logic [SAMPLE_W-1:0] y_off;
    logic [SAMPLE_W-1:0] c_off;
    logic [SHAMT_W-1:0]  shamt;   // 2 * depth
    coef_t               coef;
  } cfg_t;

  // round a 24-bit-scale multiplier down to the sample depth
  function automatic logic signed [COEF_W-1:0] round_coef(
    input logic signed [COEF_W-1:0] m,
    input logic [DEPTH_W-1:0]       dep
  );
    logic signed [COEF_W:0] t;
    if (dep >= DEPTH_MAX) begin
      return m;
    end
    t = (COEF_W+1)'(m) + ((COEF_W+1)'(1) << (DEPTH_W'(15) - dep));
    t = t >>> (DEPTH_W'(16) - dep);
    return COEF_W'(t);
  endfunction

  function automatic cfg_t derive_cfg(
    input logic [STD_W-1:0]   std,
    input logic [DEPTH_W-1:0] depth
  );
    cfg_t                 c;
    logic [DEPTH_W-1:0]   dep;
    logic [STD_W-1:0]     s8;
    logic                 hi;
    logic [SAMPLE_W:0]    full;
    dep = (depth < DEPTH_MIN) ? DEPTH_MIN : ((depth > DEPTH_MAX) ? DEPTH_MAX : depth);
    s8  = (std == STD_RSV) ? STD_709 : std;
    hi  = (std == STD_601) ? 1'b0 : 1'b1;
    full    = ((SAMPLE_W+1)'(1) << dep) - (SAMPLE_W+1)'(1);
    c.mask  = full[SAMPLE_W-1:0];
    c.y_off = SAMPLE_W'(16) << (dep - DEPTH_MIN);
    c.c_off = SAMPLE_W'(128) << (dep - DEPTH_MIN);
    c.shamt = {dep, 1'b0};
    if (dep == DEPTH_MIN) begin
      c.coef.luma = COEF8[s8][0];
      c.coef.r_cr = COEF8[s8][1];
      c.coef.g_cb = COEF8[s8][2];
      c.coef.g_cr = COEF8[s8][3];
      c.coef.b_cb = COEF8[s8][4];
    end else begin
      c.coef.luma = round_coef(COEFHI[hi][0], dep);
      c.coef.r_cr = round_coef(COEFHI[hi][1], dep);
      c.coef.g_cb = round_coef(COEFHI[hi][2], dep);
      c.coef.g_cr = round_coef(COEFHI[hi][3], dep);
      c.coef.b_cb = round_coef(COEFHI[hi][4], dep);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/y2r_cfg.sv =====
// configuration registers and derived per-depth constants (mask, offsets, coefficients)
// depends on y2r_pkg
`default_nettype none

module y2r_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [y2r_pkg::CFG_W-1:0]     cfg_data,
  output y2r_pkg::cfg_t                      cfg_o
);
  import y2r_pkg::*;

  logic [STD_W-1:0]   std_r,   std_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  cfg_t               cfg_r;

  always_comb begin
    std_nxt   = std_r;
    depth_nxt = depth_r;
    if (!rst_n) begin
      std_nxt   = STD_RESET;
      depth_nxt = DEPTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STD:   std_nxt   = cfg_data[STD_W-1:0];
        REG_DEPTH: depth_nxt = cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // derived set follows the raw registers in the same cycle
  always_ff @(posedge clk) begin
    std_r   <= std_nxt;
    depth_r <= depth_nxt;
    cfg_r   <= derive_cfg(std_nxt, depth_nxt);
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== sv/y2r_pipe.sv =====
// four-stage conversion pipeline: offset removal, products, sums, shift and saturate
// depends on y2r_pkg; constants come from y2r_cfg
`default_nettype none

module y2r_pipe (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire y2r_pkg::cfg_t                cfg_i,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [y2r_pkg::SAMPLE_W-1:0] in_luma,
  input  wire logic [y2r_pkg::SAMPLE_W-1:0] in_chroma_blue,
  input  wire logic [y2r_pkg::SAMPLE_W-1:0] in_chroma_red,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [y2r_pkg::COLOR_W-1:0]       out_red,
  output logic [y2r_pkg::COLOR_W-1:0]       out_green,
  output logic [y2r_pkg::COLOR_W-1:0]       out_blue
);
  import y2r_pkg::*;

  function automatic logic [COLOR_W-1:0] sat8(
    input logic signed [SUM_W-1:0] s,
    input logic [SHAMT_W-1:0]      sh
  );
    logic [SUM_W-1:0] t;
    t = SUM_W'(s) >> sh;
    if (s[SUM_W-1]) begin
      return '0;
    end else if (|t[SUM_W-1:COLOR_W]) begin
      return '1;
    end
    return t[COLOR_W-1:0];
  endfunction

  logic vld1_r, vld2_r, vld3_r, vld4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [SMP_W-1:0]  lu1_r, cb1_r, cr1_r;
  logic signed [PROD_W-1:0] py2_r, prv2_r, pgu2_r, pgv2_r, pbu2_r;
  logic signed [SUM_W-1:0]  sr3_r, sg3_r, sb3_r;
  logic [COLOR_W-1:0]       red4_r, green4_r, blue4_r;

  // each stage moves when it is empty or the next one moves
  assign rdy4 = !vld4_r || out_ready;
  assign rdy3 = !vld3_r || rdy4;
  assign rdy2 = !vld2_r || rdy3;
  assign rdy1 = !vld1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      lu1_r <= SMP_W'(in_luma & cfg_i.mask) - SMP_W'(cfg_i.y_off);
      cb1_r <= SMP_W'(in_chroma_blue & cfg_i.mask) - SMP_W'(cfg_i.c_off);
      cr1_r <= SMP_W'(in_chroma_red & cfg_i.mask) - SMP_W'(cfg_i.c_off);
    end
    if (rdy2 && vld1_r) begin
      py2_r  <= PROD_W'(lu1_r) * PROD_W'(cfg_i.coef.luma);
      prv2_r <= PROD_W'(cr1_r) * PROD_W'(cfg_i.coef.r_cr);
      pgu2_r <= PROD_W'(cb1_r) * PROD_W'(cfg_i.coef.g_cb);
      pgv2_r <= PROD_W'(cr1_r) * PROD_W'(cfg_i.coef.g_cr);
      pbu2_r <= PROD_W'(cb1_r) * PROD_W'(cfg_i.coef.b_cb);
    end
    if (rdy3 && vld2_r) begin
      sr3_r <= SUM_W'(py2_r) + SUM_W'(prv2_r);
      sg3_r <= SUM_W'(py2_r) + SUM_W'(pgu2_r) + SUM_W'(pgv2_r);
      sb3_r <= SUM_W'(py2_r) + SUM_W'(pbu2_r);
    end
    // shifting by 2*depth folds the floor shift, the clamp and the drop to 8 bits
    if (rdy4 && vld3_r) begin
      red4_r   <= sat8(sr3_r, cfg_i.shamt);
      green4_r <= sat8(sg3_r, cfg_i.shamt);
      blue4_r  <= sat8(sb3_r, cfg_i.shamt);
    end
  end

  assign out_valid = vld4_r;
  assign out_red   = red4_r;
  assign out_green = green4_r;
  assign out_blue  = blue4_r;

endmodule

`default_nettype wire

// ===== sv/yuv444_to_rgb888_converter.sv =====
// top level of the yuv444 to rgb888 converter: configuration block and conversion pipeline
// depends on y2r_pkg, y2r_cfg and y2r_pipe
`default_nettype none

// Converts one limited-range Y/Cb/Cr triple per transaction into one 8-bit RGB pixel
// with BT.601, BT.709 or BT.2020 (8-bit only) coefficients at 8 to 16 bits per sample.
// Throughput is one pixel per clock while the output is not stalled; each pixel passes
// through the four pipeline stages (offset removal, multiply, sum, saturate) in turn.
// Each stage holds while the next cannot move, so a stalled output back-pressures the
// input only once all four stages are occupied. Configuration writes take effect on
// the next cycle and must be made with the pipeline empty.

module yuv444_to_rgb888_converter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [y2r_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [y2r_pkg::SAMPLE_W-1:0]  in_luma,
  input  wire logic [y2r_pkg::SAMPLE_W-1:0]  in_chroma_blue,
  input  wire logic [y2r_pkg::SAMPLE_W-1:0]  in_chroma_red,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [y2r_pkg::COLOR_W-1:0]        out_red,
  output logic [y2r_pkg::COLOR_W-1:0]        out_green,
  output logic [y2r_pkg::COLOR_W-1:0]        out_blue
);
  import y2r_pkg::*;

  cfg_t cfg;

  y2r_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  y2r_pipe u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  // an empty output stage means every stage can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

  a_no_output_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a transaction must pass every pipeline stage before it reaches the output
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("output valid before pipeline latency");

endmodule

`default_nettype wire

// ===== bench/rgb_pixel_checker.sv =====
// pixel checker for the yuv444 to rgb888 converter: tracks register writes, predicts
// each rgb pixel from the accepted y/cb/cr transaction and compares in order
// depends on y2r_pkg for widths, register indexes and standard codes
`timescale 1ns / 100ps

module rgb_pixel_checker
  import y2r_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_luma,
  input  wire logic [SAMPLE_W-1:0]  in_chroma_blue,
  input  wire logic [SAMPLE_W-1:0]  in_chroma_red,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [COLOR_W-1:0]   out_red,
  input  wire logic [COLOR_W-1:0]   out_green,
  input  wire logic [COLOR_W-1:0]   out_blue,
  output int                        mismatches,
  output int                        pixels_waiting
);

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_pixel_t;

  rgb_pixel_t         expected_pixels[$];
  logic [STD_W-1:0]   active_std;
  logic [DEPTH_W-1:0] active_depth;

  function automatic rgb_pixel_t convert_pixel(
    input logic [SAMPLE_W-1:0] luma,
    input logic [SAMPLE_W-1:0] cb,
    input logic [SAMPLE_W-1:0] cr,
    input logic [STD_W-1:0]    std,
    input logic [DEPTH_W-1:0]  depth
  );
    int unsigned d;
    int unsigned shift;
    longint      mask, top, y, u, v, yt, t;
    longint      m[5];
    longint      sums[3];
    rgb_pixel_t  px;
    d = (depth < 8) ? 8 : ((depth > 16) ? 16 : depth);
    mask = (64'sd1 << d) - 1;
    top  = mask;
    y = (longint'(luma) & mask) - (64'sd16 << (d - 8));
    u = (longint'(cb) & mask) - (64'sd128 << (d - 8));
    v = (longint'(cr) & mask) - (64'sd128 << (d - 8));
    // multiplier order: luma, red from cr, green from cb, green from cr, blue from cb
    if (d == 8) begin
      case (std)
        STD_601:  m = '{64'sd76309, 64'sd104597, -64'sd25675, -64'sd53279, 64'sd132201};
        STD_2020: m = '{64'sd76309, 64'sd110013, -64'sd12276, -64'sd42626, 64'sd140363};
        // bt.709, and the unused code maps onto it
        default:  m = '{64'sd76309, 64'sd117489, -64'sd13975, -64'sd34925, 64'sd138438};
      endcase
      shift = 16;
    end else begin
      // bt.2020 has no high-depth set and falls back to bt.709
      if (std == STD_601) begin
        m = '{64'sd19535114, 64'sd26776886, -64'sd6572681, -64'sd13639334, 64'sd33843539};
      end else begin
        m = '{64'sd19535114, 64'sd30077204, -64'sd3577718, -64'sd8940735, 64'sd35440221};
      end
      if (d < 16) begin
        foreach (m[k]) m[k] = (m[k] + (64'sd1 << (15 - d))) >>> (16 - d);
      end
      shift = 8 + d;
    end
    yt = y * m[0];
    sums[0] = yt + v * m[1];
    sums[1] = yt + u * m[2] + v * m[3];
    sums[2] = yt + u * m[4];
    foreach (sums[k]) begin
      t = sums[k] >>> shift;
      if (t < 0) t = 0;
      if (t > top) t = top;
      sums[k] = t >> (d - 8);
    end
    px.red   = COLOR_W'(sums[0]);
    px.green = COLOR_W'(sums[1]);
    px.blue  = COLOR_W'(sums[2]);
    return px;
  endfunction

  task automatic report_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch_channels
    rgb_pixel_t want;
    if (!rst_n) begin
      active_std   = STD_709;
      active_depth = 5'd8;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_STD) active_std = cfg_data[STD_W-1:0];
        else if (cfg_index == REG_DEPTH) active_depth = cfg_data[DEPTH_W-1:0];
      end
      if (in_valid && in_ready) begin
        expected_pixels.push_back(convert_pixel(in_luma, in_chroma_blue, in_chroma_red,
                                                active_std, active_depth));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_failure($sformatf("unexpected pixel r=%0d g=%0d b=%0d with nothing pending",
                                   out_red, out_green, out_blue));
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
            report_failure($sformatf(
              "pixel mismatch at %0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
              $realtime, want.red, want.green, want.blue, out_red, out_green, out_blue));
          end
        end
      end
    end
    pixels_waiting = expected_pixels.size();
  end

endmodule

// ===== bench/yuv444_to_rgb888_converter_test.sv =====
// top of the converter testbench: clock, reset, y/cb/cr stimulus across register
// settings, result-side back-pressure, watchdog and verdict
// depends on y2r_pkg, rgb_pixel_checker and the yuv444_to_rgb888_converter rtl
`timescale 1ns / 100ps

module yuv444_to_rgb888_converter_test;
  import y2r_pkg::*;

  localparam int STALL_LIMIT      = 4000;
  localparam int LONG_HOLD        = 120;
  localparam int NUM_SETTINGS     = 24;
  localparam int PIXELS_PER_SETTING = 39;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [SAMPLE_W-1:0]  in_luma = '0;
  logic [SAMPLE_W-1:0]  in_chroma_blue = '0;
  logic [SAMPLE_W-1:0]  in_chroma_red = '0;
  logic                 out_ready = 1'b0;
  wire logic            in_ready;
  wire logic            out_valid;
  wire logic [COLOR_W-1:0] out_red;
  wire logic [COLOR_W-1:0] out_green;
  wire logic [COLOR_W-1:0] out_blue;

  int mismatches;
  int pixels_waiting;
  int pixels_sent = 0;
  int pixels_received = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit sender_busy = 1'b0;

  yuv444_to_rgb888_converter u_dut (.*);

  rgb_pixel_checker u_checker (.*);

  always #4 clk = ~clk;

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid && out_ready) pixels_received <= pixels_received + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample(input int d, input int centre);
    logic [SAMPLE_W-1:0] full_scale;
    full_scale = SAMPLE_W'((32'd1 << d) - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return full_scale;
      2: return SAMPLE_W'($urandom);   // bits above the depth set too
      3: return SAMPLE_W'(centre + $urandom_range(0, 16) - 8);
      default: return SAMPLE_W'($urandom) & full_scale;
    endcase
  endfunction

  task automatic send_pixel(input logic [SAMPLE_W-1:0] luma, input logic [SAMPLE_W-1:0] cb,
                            input logic [SAMPLE_W-1:0] cr);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_luma        <= luma;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // result side: random stalls per transaction, busy stretches, one long hold-off on request
  initial begin : result_sink
    int gap;
    int taken;
    bit receiver_busy;
    taken = 0;
    receiver_busy = 1'b0;
    wait (rst_n);
    forever begin
      if (taken % 50 == 0) receiver_busy = ($urandom_range(0, 3) == 0);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = receiver_busy ? 0 : $urandom_range(0, 16);
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : pixel_source
    logic [STD_W-1:0]   std_sel;
    logic [DEPTH_W-1:0] depth_sel;
    int                 d;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pixels at the reset setting (bt.709, 8 bit)
    send_pixel(16'd16, 16'd128, 16'd128);
    send_pixel(16'd235, 16'd128, 16'd128);
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFF10, 16'h0180, 16'hAB80);   // wide samples, masked to black
    send_pixel(16'd81, 16'd90, 16'd240);
    send_pixel(16'd145, 16'd54, 16'd34);
    send_pixel(16'd41, 16'd240, 16'd110);
    send_pixel(16'd235, 16'd16, 16'd240);
    send_pixel(16'd16, 16'd240, 16'd16);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0:  begin std_sel = STD_601;  depth_sel = 5'd8;  end
        1:  begin std_sel = STD_2020; depth_sel = 5'd8;  end
        2:  begin std_sel = STD_RSV;  depth_sel = 5'd8;  end
        3:  begin std_sel = STD_709;  depth_sel = 5'd16; end
        4:  begin std_sel = STD_601;  depth_sel = 5'd16; end
        5:  begin std_sel = STD_2020; depth_sel = 5'd12; end
        6:  begin std_sel = STD_RSV;  depth_sel = 5'd9;  end
        7:  begin std_sel = STD_601;  depth_sel = 5'd0;  end
        8:  begin std_sel = STD_709;  depth_sel = 5'd31; end
        9:  begin std_sel = STD_2020; depth_sel = 5'd17; end
        10: begin std_sel = STD_601;  depth_sel = 5'd15; end
        11: begin std_sel = STD_709;  depth_sel = 5'd8;  end
        default: begin
          std_sel   = STD_W'($urandom_range(0, 3));
          depth_sel = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(0, 31))
                                                  : DEPTH_W'($urandom_range(8, 16));
        end
      endcase

      // hold input until the pipeline has drained, then rewrite both registers
      @(negedge clk);
      in_valid <= 1'b0;
      while (pixels_waiting != 0) @(negedge clk);
      repeat (2) @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_STD;
      cfg_data  <= CFG_W'(std_sel);
      @(negedge clk);
      cfg_index <= REG_DEPTH;
      cfg_data  <= CFG_W'(depth_sel);
      @(negedge clk);
      cfg_wr_en <= 1'b0;

      // back-to-back pixels against a long output stall fill the pipeline
      sender_busy = (p == 3) || ($urandom_range(0, 3) == 0);
      if (p == 3) hold_request = 1'b1;

      d = (depth_sel < 8) ? 8 : ((depth_sel > 16) ? 16 : int'(depth_sel));
      repeat (PIXELS_PER_SETTING) begin
        send_pixel(rand_sample(d, 16 << (d - 8)), rand_sample(d, 128 << (d - 8)),
                   rand_sample(d, 128 << (d - 8)));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_waiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d pixels and checked %0d results over %0d register settings",
             pixels_sent, pixels_received, NUM_SETTINGS + 1);
    $display("settings spanned all standard codes and depths from below 8 to above 16");
    if (mismatches == 0 && pixels_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== yuv444_to_rgb888_converter.f =====
sv/y2r_pkg.sv
sv/y2r_cfg.sv
sv/y2r_pipe.sv
sv/yuv444_to_rgb888_converter.sv
bench/rgb_pixel_checker.sv
bench/yuv444_to_rgb888_converter_test.sv
